// ----- hdl/pab_pkg.sv -----
// Shared types, widths and codes for the paged aligned bump allocator.
`default_nettype none

package pab_pkg;

    // Fixed field widths
    localparam int REQ_BITS   = 24;
    localparam int PAGE_BITS  = 24;
    localparam int ALIGN_BITS = 9;
    localparam int PIDX_BITS  = 4;
    localparam int OFF_BITS   = 24;
    localparam int STAT_BITS  = 2;
    localparam int RND_BITS   = REQ_BITS + 1;

    // Stream widths (whole bytes)
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    // Parameter defaults
    localparam int DEF_MAX_PAGES = 16;
    localparam int DEF_FILL_BITS = 24;

    // Remainder unit: bits retired per cycle and step count
    localparam int BITS_PER_STEP = 3;
    localparam int MOD_STEPS     = REQ_BITS / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(MOD_STEPS + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = PAGE_BITS;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_BYTES = 2'd1;

    localparam logic [PAGE_BITS-1:0]  PAGE_BYTES_RST  = 24'd65536;
    localparam logic [ALIGN_BITS-1:0] ALIGN_BYTES_RST = 9'd256;

    // Result status codes
    localparam logic [STAT_BITS-1:0] STAT_OK           = 2'd0;
    localparam logic [STAT_BITS-1:0] STAT_TOO_LARGE    = 2'd1;
    localparam logic [STAT_BITS-1:0] STAT_OUT_OF_PAGES = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } pab_state_t;

    // Round-up unit result
    typedef struct packed {
        logic                done;
        logic [RND_BITS-1:0] rounded;
    } rnd_result_t;

endpackage

`default_nettype wire

// ----- hdl/pab_fill_ram.sv -----
// Page fill level memory: one write port, one registered read port.
`default_nettype none

module pab_fill_ram #(
    parameter  int DEPTH  = 16,
    parameter  int WIDTH  = 24,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- hdl/pab_round_unit.sv -----
// Round-up unit: request size rounded up to the alignment, remainder found 3 bits a cycle.
`default_nettype none

module pab_round_unit
    import pab_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [REQ_BITS-1:0]   dividend,
    input  wire logic [ALIGN_BITS-1:0] align,
    output rnd_result_t                result
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [REQ_BITS-1:0]   req_reg;
    logic [REQ_BITS-1:0]   dvd_reg, dvd_next;
    logic [ALIGN_BITS-1:0] rem_reg, rem_next;
    logic [ALIGN_BITS-1:0] div_reg;
    logic [RND_BITS-1:0]   rounded_reg, rounded_next;

    logic [ALIGN_BITS-1:0] rem_step;
    logic [REQ_BITS-1:0]   dvd_step;

    // Restoring remainder, BITS_PER_STEP bits per cycle
    always_comb begin
        logic [ALIGN_BITS:0]   t;
        logic [ALIGN_BITS-1:0] r;
        logic [REQ_BITS-1:0]   q;
        r = rem_reg;
        q = dvd_reg;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            t = {r, q[REQ_BITS-1]};
            q = {q[REQ_BITS-2:0], 1'b0};
            if (t >= {1'b0, div_reg}) begin
                t = t - {1'b0, div_reg};
            end
            r = t[ALIGN_BITS-1:0];
        end
        rem_step = r;
        dvd_step = q;
    end

    always_comb begin
        busy_next    = busy_reg;
        done_next    = done_reg;
        step_next    = step_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        rounded_next = rounded_reg;
        if (start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            step_next = '0;
            dvd_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (step_reg == STEP_W'(MOD_STEPS)) begin
                if (rem_reg == '0) begin
                    rounded_next = RND_BITS'(req_reg);
                end else begin
                    rounded_next = RND_BITS'(req_reg) + RND_BITS'(div_reg - rem_reg);
                end
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                dvd_next  = dvd_step;
                rem_next  = rem_step;
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        rounded_reg <= rounded_next;
        if (start) begin
            req_reg <= dividend;
            // zero alignment behaves as one
            div_reg <= (align == '0) ? ALIGN_BITS'(1) : align;
        end
    end

    assign result.done    = done_reg;
    assign result.rounded = rounded_reg;

endmodule

`default_nettype wire

// ----- hdl/paged_aligned_bump_allocator.sv -----
// Top level of the paged aligned bump allocator: control, configuration and result register.
// Usage
//   s_ channel: one allocation request per beat, s_tdata[23:0] = request_bytes.
//   m_ channel: one result per request, in order.
//     m_tdata[3:0] page_index, [27:4] byte_offset, [28] opened_page, rest zero.
//     m_tuser[1:0] status: 0 ok, 1 too large, 2 out of pages.
//   cfg_ port: cfg_wr_en with cfg_index 0 writes page_bytes, 1 writes align_bytes;
//     other indexes are ignored. Write only while the block is idle.
// Timing
//   A request runs a first-fit scan of the page fill memory, one page a cycle
//   through its registered read port, beside an 8-step remainder unit for
//   the round-up. Its result beat is written in the commit state, and the
//   next request is taken once the block is back in idle after that.
//   A too-large request skips the scan and goes straight to the commit state.
// Reset
//   aresetn (synchronous, active low) restores the register defaults and
//   closes all pages. No clearing pass: a page's fill is written when it opens.
// Stall
//   The result register holds a finished beat while m_tready is low; the block
//   still takes the next request and stops before its own result until free.
`default_nettype none

module paged_aligned_bump_allocator
    import pab_pkg::*;
#(
    parameter int MAX_PAGES = DEF_MAX_PAGES,
    parameter int FILL_BITS = DEF_FILL_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // request stream; tdata: request_bytes[23:0]
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    // result stream; tdata: page_index[3:0], byte_offset[27:4], opened_page[28]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_DATA_W-1:0]        m_tdata,
    // tuser: status[1:0]
    output logic [STAT_BITS-1:0]       m_tuser,
    // configuration writes
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int PAGE_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W  = $clog2(MAX_PAGES + 1);
    // wide enough for fill + rounded size without overflow
    localparam int WIDE   = ((FILL_BITS > REQ_BITS) ? FILL_BITS : REQ_BITS) + 2;
    localparam int PIX_W  = PAGE_W + PIDX_BITS;
    localparam int OFX_W  = FILL_BITS + OFF_BITS;

    // configuration registers
    logic [PAGE_BITS-1:0]  page_bytes_reg;
    logic [ALIGN_BITS-1:0] align_bytes_reg;

    // control
    pab_state_t            state_reg, state_next;
    logic [CNT_W-1:0]      pages_open_reg, pages_open_next;
    logic [CNT_W-1:0]      issue_idx_reg, issue_idx_next;
    logic                  chk_vld_reg, chk_vld_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    // per-request payload
    logic [REQ_BITS-1:0]   req_reg, req_next;
    logic [PAGE_W-1:0]     chk_idx_reg, chk_idx_next;
    logic [PAGE_W-1:0]     page_reg, page_next;
    logic [FILL_BITS-1:0]  old_reg, old_next;
    logic                  opened_reg, opened_next;
    logic [STAT_BITS-1:0]  status_reg, status_next;

    // result register
    logic [PIDX_BITS-1:0]  m_page_reg, m_page_next;
    logic [OFF_BITS-1:0]   m_off_reg, m_off_next;
    logic                  m_open_reg, m_open_next;
    logic [STAT_BITS-1:0]  m_stat_reg, m_stat_next;

    // memory ports
    logic                  ram_we;
    logic [PAGE_W-1:0]     ram_waddr;
    logic [FILL_BITS-1:0]  ram_wdata;
    logic [PAGE_W-1:0]     ram_raddr;
    logic [FILL_BITS-1:0]  ram_rdata;

    rnd_result_t           rnd;
    logic                  s_accept;
    logic                  too_large_now;
    logic                  fits_now;
    logic                  found_now;
    logic                  none_left;
    logic                  commit_go;
    logic [WIDE-1:0]       fill_sum;
    logic [WIDE-1:0]       fill_lim;
    logic [WIDE-1:0]       fill_new;
    logic [PIX_W-1:0]      page_ext;
    logic [OFX_W-1:0]      off_ext;

    //------------------------------------------------------------------
    // Configuration
    //------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_bytes_reg  <= PAGE_BYTES_RST;
            align_bytes_reg <= ALIGN_BYTES_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PAGE_BYTES:  page_bytes_reg  <= cfg_wdata;
                CFG_ALIGN_BYTES: align_bytes_reg <= cfg_wdata[ALIGN_BITS-1:0];
                default: ;
            endcase
        end
    end

    //------------------------------------------------------------------
    // Submodules
    //------------------------------------------------------------------
    pab_fill_ram #(
        .DEPTH (MAX_PAGES),
        .WIDTH (FILL_BITS)
    ) u_fill_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    pab_round_unit u_round (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_accept),
        .dividend (s_tdata[REQ_BITS-1:0]),
        .align    (align_bytes_reg),
        .result   (rnd)
    );

    //------------------------------------------------------------------
    // Status terms
    //------------------------------------------------------------------
    assign s_tready      = (state_reg == ST_IDLE);
    assign s_accept      = s_tvalid && s_tready;
    assign too_large_now = (s_tdata[REQ_BITS-1:0] >= page_bytes_reg);

    // room = page - fill, none once the fill has reached the page size;
    // a zero-size request still fits a page with no room
    assign fits_now  = (WIDE'(ram_rdata) >= WIDE'(page_bytes_reg)) ? (req_reg == '0) :
                       (WIDE'(req_reg) <= (WIDE'(page_bytes_reg) - WIDE'(ram_rdata)));
    assign found_now = chk_vld_reg && fits_now;
    assign none_left = !chk_vld_reg && (issue_idx_reg == pages_open_reg);

    assign commit_go = ((status_reg != STAT_OK) || rnd.done) &&
                       (!m_tvalid_reg || m_tready);

    // saturating new fill
    assign fill_sum = WIDE'(old_reg) + WIDE'(rnd.rounded);
    assign fill_lim = (WIDE'(page_bytes_reg) < WIDE'({FILL_BITS{1'b1}})) ?
                      WIDE'(page_bytes_reg) : WIDE'({FILL_BITS{1'b1}});
    assign fill_new = (fill_sum > fill_lim) ? fill_lim : fill_sum;

    assign page_ext = PIX_W'(page_reg);
    assign off_ext  = OFX_W'(old_reg);

    //------------------------------------------------------------------
    // Next state
    //------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = too_large_now ? ST_COMMIT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (found_now || none_left) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (commit_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    //------------------------------------------------------------------
    // Datapath and outputs
    //------------------------------------------------------------------
    always_comb begin
        pages_open_next = pages_open_reg;
        issue_idx_next  = issue_idx_reg;
        chk_vld_next    = chk_vld_reg;
        req_next        = req_reg;
        chk_idx_next    = chk_idx_reg;
        page_next       = page_reg;
        old_next        = old_reg;
        opened_next     = opened_reg;
        status_next     = status_reg;
        ram_we          = 1'b0;
        ram_waddr       = page_reg;
        ram_wdata       = fill_new[FILL_BITS-1:0];
        ram_raddr       = issue_idx_reg[PAGE_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    req_next       = s_tdata[REQ_BITS-1:0];
                    issue_idx_next = '0;
                    chk_vld_next   = 1'b0;
                    opened_next    = 1'b0;
                    status_next    = too_large_now ? STAT_TOO_LARGE : STAT_OK;
                end
            end
            ST_SCAN: begin
                // one read issued per cycle, checked the cycle after
                chk_vld_next = (issue_idx_reg < pages_open_reg) && !found_now;
                chk_idx_next = issue_idx_reg[PAGE_W-1:0];
                if (issue_idx_reg < pages_open_reg) begin
                    issue_idx_next = issue_idx_reg + CNT_W'(1);
                end
                if (found_now) begin
                    page_next   = chk_idx_reg;
                    old_next    = ram_rdata;
                    opened_next = 1'b0;
                    status_next = STAT_OK;
                end else if (none_left) begin
                    if (pages_open_reg == CNT_W'(MAX_PAGES)) begin
                        opened_next = 1'b0;
                        status_next = STAT_OUT_OF_PAGES;
                    end else begin
                        // fresh page starts empty
                        page_next   = pages_open_reg[PAGE_W-1:0];
                        old_next    = '0;
                        opened_next = 1'b1;
                        status_next = STAT_OK;
                    end
                end
            end
            ST_COMMIT: begin
                if (commit_go && (status_reg == STAT_OK)) begin
                    ram_we = 1'b1;
                    if (opened_reg) begin
                        pages_open_next = pages_open_reg + CNT_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // result register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_page_next   = m_page_reg;
        m_off_next    = m_off_reg;
        m_open_next   = m_open_reg;
        m_stat_next   = m_stat_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if ((state_reg == ST_COMMIT) && commit_go) begin
            m_tvalid_next = 1'b1;
            m_stat_next   = status_reg;
            if (status_reg == STAT_OK) begin
                m_page_next = page_ext[PIDX_BITS-1:0];
                m_off_next  = off_ext[OFF_BITS-1:0];
                m_open_next = opened_reg;
            end else begin
                m_page_next = '0;
                m_off_next  = '0;
                m_open_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pages_open_reg <= '0;
            issue_idx_reg  <= '0;
            chk_vld_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pages_open_reg <= pages_open_next;
            issue_idx_reg  <= issue_idx_next;
            chk_vld_reg    <= chk_vld_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        chk_idx_reg <= chk_idx_next;
        page_reg    <= page_next;
        old_reg     <= old_next;
        opened_reg  <= opened_next;
        status_reg  <= status_next;
        m_page_reg  <= m_page_next;
        m_off_reg   <= m_off_next;
        m_open_reg  <= m_open_next;
        m_stat_reg  <= m_stat_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'({m_open_reg, m_off_reg, m_page_reg});
    assign m_tuser  = m_stat_reg;

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    a_pages_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pages_open_reg <= CNT_W'(MAX_PAGES))
        else $error("open page count beyond page limit");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_stat_reg != STAT_OK)) |->
        ((m_page_reg == '0) && (m_off_reg == '0) && !m_open_reg))
        else $error("error result carries non-zero payload");

    a_open_on_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$stable(pages_open_reg)) |->
        $past((state_reg == ST_COMMIT) && commit_go && opened_reg))
        else $error("page opened outside a commit");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && !opened_reg) |-> (CNT_W'(page_reg) < pages_open_reg))
        else $error("fill written to a page that is not open");

    a_open_at_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && opened_reg) |-> (CNT_W'(page_reg) == pages_open_reg))
        else $error("new page is not the next unopened page");

endmodule

`default_nettype wire
